// ===== sv/pic_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pic_pkg
// Shared types, codes and priority helpers for the interrupt controller.
// ----------------------------------------------------------------------------
package pic_pkg;

    localparam int LINES = 8;
    localparam logic [7:0] ELCR_MASK_RESET = 8'hff;

    localparam logic [1:0] CMD_LINE  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;
    localparam logic [1:0] CMD_ACK   = 2'd3;

    localparam logic [1:0] PORT_CMD  = 2'd0;
    localparam logic [1:0] PORT_DATA = 2'd1;

    localparam logic [1:0] PHASE_IDLE = 2'd0;
    localparam logic [1:0] PHASE_ICW2 = 2'd1;
    localparam logic [1:0] PHASE_ICW3 = 2'd2;
    localparam logic [1:0] PHASE_ICW4 = 2'd3;

    localparam logic [2:0] OCW2_ROT_AEOI_CLR = 3'd0;
    localparam logic [2:0] OCW2_EOI          = 3'd1;
    localparam logic [2:0] OCW2_SPEC_EOI     = 3'd3;
    localparam logic [2:0] OCW2_ROT_AEOI_SET = 3'd4;
    localparam logic [2:0] OCW2_ROT_EOI      = 3'd5;
    localparam logic [2:0] OCW2_SET_PRIO     = 3'd6;
    localparam logic [2:0] OCW2_ROT_SPEC_EOI = 3'd7;

    localparam int MF_INIT4    = 0;
    localparam int MF_AEOI     = 1;
    localparam int MF_ROT_AEOI = 2;
    localparam int MF_SFNM     = 3;
    localparam int MF_POLL     = 4;
    localparam int MF_RISR     = 5;
    localparam int MF_SMASK    = 6;

    localparam logic [7:0] POLL_NONE = 8'h07;

    typedef struct packed {
        logic [1:0] cmd;
        logic [2:0] line_index;
        logic       line_level;
        logic [1:0] port_select;
        logic [7:0] write_byte;
    } pic_item_t;

    typedef struct packed {
        logic [7:0] read_byte;
        logic       interrupt_request;
        logic [2:0] pending_line;
        logic [7:0] vector_base;
    } pic_result_t;

    typedef struct packed {
        logic       found;
        logic [2:0] rank;
    } pic_rank_t;

    typedef struct packed {
        logic       hit;
        logic [2:0] line;
    } pic_pend_t;

    function automatic pic_rank_t pic_rank(input logic [7:0] bits, input logic [2:0] rot);
        logic [15:0] dbl;
        logic [7:0]  rotd;
        pic_rank_t   r;
        dbl = {bits, bits};
        rotd = dbl[rot +: 8];
        r.found = |rotd;
        r.rank = '0;
        for (int i = LINES - 1; i >= 0; i--)
        begin
            if (rotd[i])
            begin
                r.rank = 3'(i);
            end
        end
        return r;
    endfunction

    function automatic pic_pend_t pic_pending(input logic [7:0] irr, input logic [7:0] imr,
                                              input logic [7:0] isr, input logic smask,
                                              input logic [2:0] rot);
        pic_rank_t req;
        pic_rank_t svc;
        pic_pend_t p;
        req = pic_rank(irr & ~imr, rot);
        svc = pic_rank(smask ? (isr & ~imr) : isr, rot);
        p.hit = req.found && (!svc.found || (req.rank < svc.rank));
        p.line = p.hit ? 3'(req.rank + rot) : 3'd0;
        return p;
    endfunction

endpackage

// ===== sv/pic_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pic_core
// Controller state and the update applied for one item.
// ----------------------------------------------------------------------------
module pic_core
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  pic_pkg::pic_item_t   item,
    input  logic [7:0]           elcr_wmask,
    output pic_pkg::pic_result_t result
);

    logic [7:0] irr_reg, irr_next;
    logic [7:0] prev_reg, prev_next;
    logic [7:0] imr_reg, imr_next;
    logic [7:0] isr_reg, isr_next;
    logic [7:0] elcr_reg, elcr_next;
    logic [2:0] rot_reg, rot_next;
    logic [4:0] base_reg, base_next;
    logic [1:0] phase_reg, phase_next;
    logic [6:0] mf_reg, mf_next;

    logic [7:0]         m;
    logic [7:0]         wb;
    logic [7:0]         rd;
    logic [7:0]         wbit;
    pic_pkg::pic_rank_t isr_rank;
    pic_pkg::pic_pend_t poll_p;
    pic_pkg::pic_pend_t out_p;
    logic [2:0]         eoi_line;

    always_comb
    begin
        m = 8'd1 << item.line_index;
        wb = item.write_byte;
        wbit = 8'd1 << wb[2:0];
        isr_rank = pic_pkg::pic_rank(isr_reg, rot_reg);
        eoi_line = 3'(isr_rank.rank + rot_reg);
        poll_p = pic_pkg::pic_pending(irr_reg, imr_reg, isr_reg, mf_reg[pic_pkg::MF_SMASK],
                                      rot_reg);
        irr_next = irr_reg;
        prev_next = prev_reg;
        imr_next = imr_reg;
        isr_next = isr_reg;
        elcr_next = elcr_reg;
        rot_next = rot_reg;
        base_next = base_reg;
        phase_next = phase_reg;
        mf_next = mf_reg;
        rd = '0;
        unique case (item.cmd)
            pic_pkg::CMD_LINE:
            begin
                if (|(elcr_reg & m))
                begin
                    irr_next = item.line_level ? (irr_reg | m) : (irr_reg & ~m);
                    prev_next = item.line_level ? (prev_reg | m) : (prev_reg & ~m);
                end
                else if (item.line_level)
                begin
                    if (!(|(prev_reg & m)))
                    begin
                        irr_next = irr_reg | m;
                    end
                    prev_next = prev_reg | m;
                end
                else
                begin
                    prev_next = prev_reg & ~m;
                end
            end
            pic_pkg::CMD_WRITE:
            begin
                if (item.port_select[1])
                begin
                    elcr_next = wb & elcr_wmask;
                end
                else if (item.port_select == pic_pkg::PORT_CMD)
                begin
                    if (wb[4])
                    begin
                        irr_next = '0;
                        prev_next = '0;
                        imr_next = '0;
                        isr_next = '0;
                        rot_next = '0;
                        base_next = '0;
                        phase_next = pic_pkg::PHASE_ICW2;
                        mf_next = '0;
                        mf_next[pic_pkg::MF_INIT4] = wb[0];
                    end
                    else if (wb[3])
                    begin
                        if (wb[2])
                        begin
                            mf_next[pic_pkg::MF_POLL] = 1'b1;
                        end
                        if (wb[1])
                        begin
                            mf_next[pic_pkg::MF_RISR] = wb[0];
                        end
                        if (wb[6])
                        begin
                            mf_next[pic_pkg::MF_SMASK] = wb[5];
                        end
                    end
                    else
                    begin
                        case (wb[7:5]) inside
                            pic_pkg::OCW2_ROT_AEOI_CLR: mf_next[pic_pkg::MF_ROT_AEOI] = 1'b0;
                            pic_pkg::OCW2_ROT_AEOI_SET: mf_next[pic_pkg::MF_ROT_AEOI] = 1'b1;
                            pic_pkg::OCW2_EOI, pic_pkg::OCW2_ROT_EOI:
                            begin
                                if (isr_rank.found)
                                begin
                                    isr_next = isr_reg & ~(8'd1 << eoi_line);
                                    if (wb[7:5] == pic_pkg::OCW2_ROT_EOI)
                                    begin
                                        rot_next = 3'(eoi_line + 3'd1);
                                    end
                                end
                            end
                            pic_pkg::OCW2_SPEC_EOI: isr_next = isr_reg & ~wbit;
                            pic_pkg::OCW2_SET_PRIO: rot_next = 3'(wb[2:0] + 3'd1);
                            pic_pkg::OCW2_ROT_SPEC_EOI:
                            begin
                                isr_next = isr_reg & ~wbit;
                                rot_next = 3'(wb[2:0] + 3'd1);
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                else
                begin
                    unique case (phase_reg)
                        pic_pkg::PHASE_IDLE: imr_next = wb;
                        pic_pkg::PHASE_ICW2:
                        begin
                            base_next = wb[7:3];
                            phase_next = pic_pkg::PHASE_ICW3;
                        end
                        pic_pkg::PHASE_ICW3:
                        begin
                            phase_next = mf_reg[pic_pkg::MF_INIT4] ? pic_pkg::PHASE_ICW4
                                                                  : pic_pkg::PHASE_IDLE;
                        end
                        default:
                        begin
                            mf_next[pic_pkg::MF_SFNM] = wb[4];
                            mf_next[pic_pkg::MF_AEOI] = wb[1];
                            phase_next = pic_pkg::PHASE_IDLE;
                        end
                    endcase
                end
            end
            pic_pkg::CMD_READ:
            begin
                if (item.port_select[1])
                begin
                    rd = elcr_reg;
                end
                else if (mf_reg[pic_pkg::MF_POLL])
                begin
                    mf_next[pic_pkg::MF_POLL] = 1'b0;
                    if (poll_p.hit)
                    begin
                        rd = {5'd0, poll_p.line};
                        irr_next = irr_reg & ~(8'd1 << poll_p.line);
                        isr_next = isr_reg & ~(8'd1 << poll_p.line);
                    end
                    else
                    begin
                        rd = pic_pkg::POLL_NONE;
                    end
                end
                else if (item.port_select == pic_pkg::PORT_CMD)
                begin
                    rd = mf_reg[pic_pkg::MF_RISR] ? isr_reg : irr_reg;
                end
                else
                begin
                    rd = imr_reg;
                end
            end
            default:
            begin
                if (mf_reg[pic_pkg::MF_AEOI])
                begin
                    if (mf_reg[pic_pkg::MF_ROT_AEOI])
                    begin
                        rot_next = 3'(item.line_index + 3'd1);
                    end
                end
                else
                begin
                    isr_next = isr_reg | m;
                end
                if (!(|(elcr_reg & m)))
                begin
                    irr_next = irr_reg & ~m;
                end
            end
        endcase
        out_p = pic_pkg::pic_pending(irr_next, imr_next, isr_next,
                                     mf_next[pic_pkg::MF_SMASK], rot_next);
        result.read_byte = rd;
        result.interrupt_request = out_p.hit;
        result.pending_line = out_p.line;
        result.vector_base = {base_next, 3'd0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            irr_reg <= '0;
            prev_reg <= '0;
            imr_reg <= '0;
            isr_reg <= '0;
            elcr_reg <= '0;
            rot_reg <= '0;
            base_reg <= '0;
            phase_reg <= pic_pkg::PHASE_IDLE;
            mf_reg <= '0;
        end
        else if (en)
        begin
            irr_reg <= irr_next;
            prev_reg <= prev_next;
            imr_reg <= imr_next;
            isr_reg <= isr_next;
            elcr_reg <= elcr_next;
            rot_reg <= rot_next;
            base_reg <= base_next;
            phase_reg <= phase_next;
            mf_reg <= mf_next;
        end
    end

endmodule

// ===== sv/programmable_interrupt_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// programmable_interrupt_controller
// Single 8-input 8259A-style interrupt controller on a stream interface.
// ----------------------------------------------------------------------------
// One item per clock while the output register is not held: an item is
// captured in the input register, then applied to the controller state by
// one pass of update and rotating priority logic, and its result lands in
// the output register as the state is updated. The output register stalls
// the chain only while a result waits on m_axis_tready.
// The ELCR writable mask resets to all ones and is written through cfg_we.
module programmable_interrupt_controller
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // line_index, line_level, port_select, write_byte
    input  logic [1:0]  s_axis_tuser,  // cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata   // read_byte, interrupt_request, pending_line,
                                       // vector_base
);

    logic [7:0]           elcr_wmask_reg;
    logic                 in_valid_reg;
    pic_pkg::pic_item_t   in_item_reg;
    logic                 out_valid_reg;
    pic_pkg::pic_result_t out_res_reg;
    pic_pkg::pic_result_t res;
    logic                 advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    pic_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (advance),
        .item       (in_item_reg),
        .elcr_wmask (elcr_wmask_reg),
        .result     (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elcr_wmask_reg <= pic_pkg::ELCR_MASK_RESET;
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                elcr_wmask_reg <= cfg_wdata;
            end
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_item_reg.cmd <= s_axis_tuser;
            in_item_reg.line_index <= s_axis_tdata[2:0];
            in_item_reg.line_level <= s_axis_tdata[3];
            in_item_reg.port_select <= s_axis_tdata[5:4];
            in_item_reg.write_byte <= s_axis_tdata[13:6];
        end
        if (advance)
        begin
            out_res_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = {4'd0, out_res_reg.vector_base, out_res_reg.pending_line,
                           out_res_reg.interrupt_request, out_res_reg.read_byte};

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_axis_tready)
        else $error("input stalled with empty output register");

    a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("processed item produced no result");

    a_no_line_without_irq: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_res_reg.interrupt_request) |-> (out_res_reg.pending_line == 3'd0))
        else $error("pending line set without a request");

    a_vector_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_res_reg.vector_base[2:0] == 3'd0))
        else $error("vector base not aligned");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 8259A-style interrupt controller. Streams
// directed and random line, register and acknowledge items through the
// block, tracks the controller state alongside it and checks every status
// item in order, over several settings of the ELCR writable mask.
// ----------------------------------------------------------------------------
module tb_top;
    import pic_pkg::*;

    localparam logic [1:0] PORT_ELCR     = 2'd2;
    localparam logic [1:0] PORT_ELCR_ALT = 2'd3;
    localparam int         ICW1_BIT      = 4;
    localparam int         OCW3_BIT      = 3;
    localparam int         IDLE_PCT      = 30;
    localparam int         PHASE_ITEMS   = 215;
    localparam int         DRAIN_CYCLES  = 8;
    localparam int         CYCLE_LIMIT   = 100000;
    localparam int         REPORT_MAX    = 10;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        cfg_we        = 1'b0;
    logic [7:0]  cfg_wdata     = 8'h00;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;  // line_index, line_level, port_select, write_byte
    logic [1:0]  s_axis_tuser  = '0;  // cmd
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;        // read_byte, interrupt_request, pending_line,
                                      // vector_base

    programmable_interrupt_controller DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Controller state as tracked by the bench
    logic [7:0] elcr_wmask;
    logic [7:0] irr;
    logic [7:0] prev_lv;
    logic [7:0] imr;
    logic [7:0] isr;
    logic [7:0] elcr;
    logic [2:0] rot;
    logic [4:0] base_hi;
    logic [1:0] phase;
    logic [6:0] flags;

    pic_item_t   item_q[$];
    pic_result_t status_q[$];
    pic_item_t   cur_item;
    logic        steady = 1'b0;
    int          bad_count = 0;
    int          cycle_count = 0;

    function automatic void clear_core();
        irr     = '0;
        prev_lv = '0;
        imr     = '0;
        isr     = '0;
        rot     = '0;
        base_hi = '0;
        phase   = PHASE_IDLE;
        flags   = '0;
    endfunction

    function automatic int rank_of(input logic [7:0] bits);
        for (int r = 0; r < LINES; r++)
        begin
            if (bits[3'(r + rot)])
            begin
                return r;
            end
        end
        return LINES;
    endfunction

    function automatic pic_pend_t top_request();
        int         req;
        logic [7:0] svc;
        pic_pend_t  p;
        req = rank_of(irr & ~imr);
        svc = flags[MF_SMASK] ? (isr & ~imr) : isr;
        p.hit = (req < LINES) && (req < rank_of(svc));
        p.line = p.hit ? 3'(req + rot) : 3'd0;
        return p;
    endfunction

    function automatic void write_command(input logic [7:0] v);
        int         r;
        logic [2:0] ln;
        logic [2:0] code;
        code = v[7:5];
        if (v[ICW1_BIT])
        begin
            clear_core();
            phase = PHASE_ICW2;
            flags[MF_INIT4] = v[0];
        end
        else if (v[OCW3_BIT])
        begin
            if (v[2])
            begin
                flags[MF_POLL] = 1'b1;
            end
            if (v[1])
            begin
                flags[MF_RISR] = v[0];
            end
            if (v[6])
            begin
                flags[MF_SMASK] = v[5];
            end
        end
        else
        begin
            case (code)
                OCW2_ROT_AEOI_CLR, OCW2_ROT_AEOI_SET:
                    flags[MF_ROT_AEOI] = (code == OCW2_ROT_AEOI_SET);
                OCW2_EOI, OCW2_ROT_EOI:
                begin
                    r = rank_of(isr);
                    if (r < LINES)
                    begin
                        ln = 3'(r + rot);
                        isr[ln] = 1'b0;
                        if (code == OCW2_ROT_EOI)
                        begin
                            rot = ln + 3'd1;
                        end
                    end
                end
                OCW2_SPEC_EOI:
                    isr[v[2:0]] = 1'b0;
                OCW2_SET_PRIO:
                    rot = v[2:0] + 3'd1;
                OCW2_ROT_SPEC_EOI:
                begin
                    isr[v[2:0]] = 1'b0;
                    rot = v[2:0] + 3'd1;
                end
                default:
                    ;
            endcase
        end
    endfunction

    function automatic void write_data(input logic [7:0] v);
        case (phase)
            PHASE_IDLE:
                imr = v;
            PHASE_ICW2:
            begin
                base_hi = v[7:3];
                phase = PHASE_ICW3;
            end
            PHASE_ICW3:
                phase = flags[MF_INIT4] ? PHASE_ICW4 : PHASE_IDLE;
            default:
            begin
                flags[MF_SFNM] = v[4];
                flags[MF_AEOI] = v[1];
                phase = PHASE_IDLE;
            end
        endcase
    endfunction

    function automatic logic [7:0] read_port(input logic [1:0] port);
        pic_pend_t p;
        if (port >= PORT_ELCR)
        begin
            return elcr;
        end
        if (flags[MF_POLL])
        begin
            flags[MF_POLL] = 1'b0;
            p = top_request();
            if (!p.hit)
            begin
                return POLL_NONE;
            end
            irr[p.line] = 1'b0;
            isr[p.line] = 1'b0;
            return {5'd0, p.line};
        end
        if (port == PORT_CMD)
        begin
            return flags[MF_RISR] ? isr : irr;
        end
        return imr;
    endfunction

    function automatic pic_result_t apply_item(input pic_item_t it);
        logic [7:0]  m;
        logic [7:0]  rd;
        pic_pend_t   p;
        pic_result_t res;
        m = 8'd1 << it.line_index;
        rd = 8'd0;
        case (it.cmd)
            CMD_LINE:
            begin
                if ((elcr & m) != 0)
                begin
                    if (it.line_level)
                    begin
                        irr |= m;
                        prev_lv |= m;
                    end
                    else
                    begin
                        irr &= ~m;
                        prev_lv &= ~m;
                    end
                end
                else if (it.line_level)
                begin
                    if ((prev_lv & m) == 0)
                    begin
                        irr |= m;
                    end
                    prev_lv |= m;
                end
                else
                begin
                    prev_lv &= ~m;
                end
            end
            CMD_WRITE:
            begin
                if (it.port_select >= PORT_ELCR)
                begin
                    elcr = it.write_byte & elcr_wmask;
                end
                else if (it.port_select == PORT_CMD)
                begin
                    write_command(it.write_byte);
                end
                else
                begin
                    write_data(it.write_byte);
                end
            end
            CMD_READ:
                rd = read_port(it.port_select);
            default:
            begin
                if (flags[MF_AEOI])
                begin
                    if (flags[MF_ROT_AEOI])
                    begin
                        rot = it.line_index + 3'd1;
                    end
                end
                else
                begin
                    isr |= m;
                end
                if ((elcr & m) == 0)
                begin
                    irr &= ~m;
                end
            end
        endcase
        p = top_request();
        res.read_byte = rd;
        res.interrupt_request = p.hit;
        res.pending_line = p.line;
        res.vector_base = {base_hi, 3'd0};
        return res;
    endfunction

    function automatic pic_item_t mk_item(input logic [1:0] cmd, input logic [2:0] line,
                                          input logic lvl, input logic [1:0] port,
                                          input logic [7:0] wb);
        pic_item_t it;
        it.cmd = cmd;
        it.line_index = line;
        it.line_level = lvl;
        it.port_select = port;
        it.write_byte = wb;
        return it;
    endfunction

    task automatic push_write(input logic [1:0] port, input logic [7:0] wb);
        item_q.push_back(mk_item(CMD_WRITE, 3'(wb), wb[0], port, wb));
    endtask

    task automatic push_read(input logic [1:0] port);
        item_q.push_back(mk_item(CMD_READ, 3'($urandom_range(7)), 1'($urandom), port,
                                 8'($urandom)));
    endtask

    task automatic queue_directed();
        push_read(PORT_CMD);
        push_write(PORT_CMD, 8'h11);
        push_write(PORT_DATA, 8'hf8);
        push_write(PORT_DATA, 8'h00);
        push_write(PORT_DATA, 8'h11);
        push_write(PORT_ELCR, 8'haa);
        push_write(PORT_ELCR_ALT, 8'h0f);
        item_q.push_back(mk_item(CMD_LINE, 3'd7, 1'b1, PORT_CMD, 8'h00));
        item_q.push_back(mk_item(CMD_LINE, 3'd0, 1'b1, PORT_CMD, 8'h00));
        item_q.push_back(mk_item(CMD_LINE, 3'd3, 1'b1, PORT_CMD, 8'h00));
        item_q.push_back(mk_item(CMD_ACK, 3'd0, 1'b0, PORT_CMD, 8'h00));
        item_q.push_back(mk_item(CMD_ACK, 3'd5, 1'b0, PORT_CMD, 8'h00));
        push_write(PORT_CMD, 8'h0b);
        push_read(PORT_CMD);
        push_write(PORT_CMD, 8'h0c);
        push_read(PORT_ELCR);
        push_read(PORT_DATA);
        push_write(PORT_CMD, 8'h20);
        push_write(PORT_CMD, 8'h40);
        push_write(PORT_CMD, 8'h63);
        push_write(PORT_CMD, 8'h80);
        push_write(PORT_CMD, 8'ha0);
        push_write(PORT_CMD, 8'hc7);
        push_write(PORT_CMD, 8'he2);
        push_write(PORT_CMD, 8'h68);
        push_write(PORT_DATA, 8'hff);
        push_write(PORT_CMD, 8'h0c);
        push_read(PORT_ELCR_ALT);
    endtask

    task automatic queue_random(input int count);
        int         n;
        int         pick;
        logic [7:0] v;
        n = 0;
        while (n < count)
        begin
            pick = $urandom_range(99);
            v = 8'($urandom);
            if (pick < 6)
            begin
                v[ICW1_BIT] = 1'b1;
                push_write(PORT_CMD, v);
                push_write(PORT_DATA, 8'($urandom));
                push_write(PORT_DATA, 8'($urandom));
                n += 3;
                if (v[0])
                begin
                    push_write(PORT_DATA, 8'($urandom));
                    n++;
                end
            end
            else if (pick < 40)
            begin
                item_q.push_back(mk_item(CMD_LINE, 3'($urandom_range(7)), 1'($urandom),
                                         2'($urandom), 8'($urandom)));
                n++;
            end
            else if (pick < 52)
            begin
                item_q.push_back(mk_item(CMD_ACK, 3'($urandom_range(7)), 1'($urandom),
                                         2'($urandom), 8'($urandom)));
                n++;
            end
            else if (pick < 62)
            begin
                v[ICW1_BIT] = 1'b0;
                v[OCW3_BIT] = 1'b0;
                push_write(PORT_CMD, v);
                n++;
            end
            else if (pick < 70)
            begin
                v[ICW1_BIT] = 1'b0;
                v[OCW3_BIT] = 1'b1;
                push_write(PORT_CMD, v);
                n++;
            end
            else if (pick < 76)
            begin
                push_write(PORT_DATA, v & 8'($urandom));
                n++;
            end
            else if (pick < 80)
            begin
                push_write(2'($urandom_range(PORT_ELCR, PORT_ELCR_ALT)), v);
                n++;
            end
            else if (pick < 92)
            begin
                push_read(2'($urandom_range(3)));
                n++;
            end
            else
            begin
                item_q.push_back(mk_item(2'($urandom), 3'($urandom), 1'($urandom),
                                         2'($urandom), 8'($urandom)));
                n++;
            end
        end
    endtask

    // Hold until every queued item has been taken and every status item has come
    task automatic drain();
        @(negedge clk);
        while (item_q.size() != 0 || s_axis_tvalid || status_q.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_wmask(input logic [7:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        elcr_wmask = v;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                status_q.push_back(apply_item(cur_item));
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (item_q.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT))
                begin
                    cur_item = item_q.pop_front();
                    s_axis_tdata <= {2'b00, cur_item.write_byte, cur_item.port_select,
                                     cur_item.line_level, cur_item.line_index};
                    s_axis_tuser <= cur_item.cmd;
                    s_axis_tvalid <= 1'b1;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        pic_result_t want;
        pic_result_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.read_byte = m_axis_tdata[7:0];
            got.interrupt_request = m_axis_tdata[8];
            got.pending_line = m_axis_tdata[11:9];
            got.vector_base = m_axis_tdata[19:12];
            if (status_q.size() == 0)
            begin
                bad_count++;
                if (bad_count <= REPORT_MAX)
                begin
                    $display("unexpected status item: tdata=%h", m_axis_tdata);
                end
            end
            else
            begin
                want = status_q.pop_front();
                if (got.read_byte !== want.read_byte
                    || got.interrupt_request !== want.interrupt_request
                    || got.pending_line !== want.pending_line
                    || got.vector_base !== want.vector_base)
                begin
                    bad_count++;
                    if (bad_count <= REPORT_MAX)
                    begin
                        $display("status mismatch: exp rd=%h irq=%b line=%0d base=%h",
                                 want.read_byte, want.interrupt_request,
                                 want.pending_line, want.vector_base);
                        $display("                 act rd=%h irq=%b line=%0d base=%h",
                                 got.read_byte, got.interrupt_request,
                                 got.pending_line, got.vector_base);
                    end
                end
            end
        end
        m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("programmable_interrupt_controller verification failed");
            $finish;
        end
    end

    initial
    begin
        logic [7:0] masks [5];
        masks[0] = 8'h00;
        masks[1] = 8'hff;
        masks[2] = 8'($urandom);
        masks[3] = 8'($urandom);
        masks[4] = 8'hff;
        elcr_wmask = ELCR_MASK_RESET;
        elcr = '0;
        clear_core();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        queue_directed();
        drain();
        for (int i = 0; i < 5; i++)
        begin
            write_wmask(masks[i]);
            steady = (i == 2);
            queue_random(PHASE_ITEMS);
            drain();
            steady = 1'b0;
        end
        if (bad_count == 0)
        begin
            $display("programmable_interrupt_controller verification clean");
        end
        else
        begin
            $display("programmable_interrupt_controller verification failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/pic_pkg.sv
sv/pic_core.sv
sv/programmable_interrupt_controller.sv
tb/sv/tb_top.sv
